// ===== rtl/core/msort_pkg.sv =====
// shared types and constants of the merge sorter
// used by msort_ctrl, msort_dp and merge_sorter; depends on nothing

package msort_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    // holds lo + 2 * width, which stays below three times the capacity
    localparam int SUM_W        = CNT_W + 2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_PASS,
        ST_SETUP,
        ST_MERGE,
        ST_DRAIN_READ,
        ST_DRAIN_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_END_PASS,
        OP_SETUP,
        OP_STEP,
        OP_DRAIN_START,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   drain_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic width_lt_n;
        logic lo_ge_n;
        logic merge_last;
        logic drain_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/core/msort_ram.sv =====
// generic ram: one write port, two read ports with registered read data
// no dependencies

module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/core/msort_ctrl.sv =====
// controller of the merge sorter: load, merge passes and drain sequencing
// depends on msort_pkg; drives msort_dp through dp_cmd_t

module msort_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 last_in,
    output logic                 in_stall,
    input  msort_pkg::dp_status_t status,
    output msort_pkg::dp_cmd_t    cmd
);

    import msort_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && last_in)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_PASS;
            end
            ST_PASS:
            begin
                state_next = status.width_lt_n ? ST_SETUP : ST_DRAIN_READ;
            end
            ST_SETUP:
            begin
                state_next = status.lo_ge_n ? ST_PASS : ST_MERGE;
            end
            ST_MERGE:
            begin
                if (status.merge_last)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_DRAIN_READ:
            begin
                state_next = ST_DRAIN_EMIT;
            end
            ST_DRAIN_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.drain_last ? ST_LOAD : ST_DRAIN_READ;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd.op        = OP_NONE;
        cmd.drain_sel = 1'b0;
        in_stall      = 1'b1;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_START:
            begin
                cmd.op = OP_START;
            end
            ST_PASS:
            begin
                if (!status.width_lt_n)
                begin
                    cmd.op = OP_DRAIN_START;
                end
            end
            ST_SETUP:
            begin
                cmd.op = status.lo_ge_n ? OP_END_PASS : OP_SETUP;
            end
            ST_MERGE:
            begin
                cmd.op = OP_STEP;
            end
            ST_DRAIN_READ:
            begin
                cmd.drain_sel = 1'b1;
            end
            ST_DRAIN_EMIT:
            begin
                cmd.drain_sel = 1'b1;
                if (status.out_free)
                begin
                    cmd.op = OP_EMIT;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

// ===== rtl/core/msort_dp.sv =====
// datapath of the merge sorter: two ping-pong element buffers, run pointers,
// merge compare and the output register; depends on msort_pkg and msort_ram

module msort_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  msort_pkg::dp_cmd_t                 cmd,
    output msort_pkg::dp_status_t              status,
    input  logic signed [msort_pkg::DATA_W-1:0] value,
    output logic signed [msort_pkg::DATA_W-1:0] sorted_value,
    output logic                               last_out,
    output logic                               overflow,
    output logic                               out_valid,
    input  logic                               out_stall
);

    import msort_pkg::*;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              drop_reg, drop_next;
    logic [SUM_W-1:0]  width_reg, width_next;
    logic [SUM_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              src_reg, src_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] sorted_value_reg;
    logic              last_out_reg;
    logic              overflow_reg;

    logic [SUM_W-1:0]  n_ext;
    logic [SUM_W-1:0]  lo_plus_w;
    logic [SUM_W-1:0]  lo_plus_2w;
    logic [CNT_W-1:0]  mid_calc;
    logic [CNT_W-1:0]  hi_calc;
    logic [CNT_W-1:0]  k_inc;
    logic              room;
    logic              i_lt_mid;
    logic              j_lt_hi;
    logic              take_left;
    logic [DATA_W-1:0] src_a;
    logic [DATA_W-1:0] src_b;
    logic [DATA_W-1:0] winner;
    logic              is_load;
    logic              is_step;
    logic              is_emit;

    logic              wr_en0, wr_en1;
    logic [ADDR_W-1:0] wr_addr0;
    logic [DATA_W-1:0] wr_data0;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

    assign is_load = (cmd.op == OP_LOAD);
    assign is_step = (cmd.op == OP_STEP);
    assign is_emit = (cmd.op == OP_EMIT);

    assign n_ext      = SUM_W'(count_reg);
    assign lo_plus_w  = lo_reg + width_reg;
    assign lo_plus_2w = lo_reg + (width_reg << 1);
    assign mid_calc   = (lo_plus_w < n_ext) ? lo_plus_w[CNT_W-1:0] : count_reg;
    assign hi_calc    = (lo_plus_2w < n_ext) ? lo_plus_2w[CNT_W-1:0] : count_reg;
    assign k_inc      = k_reg + CNT_W'(1);
    assign room       = (count_reg < CNT_W'(MAX_ELEMENTS));

    assign src_a    = src_reg ? rd1_a : rd0_a;
    assign src_b    = src_reg ? rd1_b : rd0_b;
    assign i_lt_mid = (i_reg < mid_reg);
    assign j_lt_hi  = (j_reg < hi_reg);
    // stable merge: the left run wins on ties
    assign take_left = i_lt_mid && (!j_lt_hi || ($signed(src_a) <= $signed(src_b)));
    assign winner    = take_left ? src_a : src_b;

    assign status.width_lt_n = (width_reg < n_ext);
    assign status.lo_ge_n    = (lo_reg >= n_ext);
    assign status.merge_last = (k_inc == hi_reg);
    assign status.drain_last = (k_inc == count_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        count_next     = count_reg;
        drop_next      = drop_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (cmd.op)
            OP_LOAD:
            begin
                if (room)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    drop_next = 1'b1;
                end
            end
            OP_START:
            begin
                width_next = SUM_W'(1);
                lo_next    = '0;
                src_next   = 1'b0;
            end
            OP_END_PASS:
            begin
                width_next = width_reg << 1;
                lo_next    = '0;
                src_next   = !src_reg;
            end
            OP_SETUP:
            begin
                mid_next = mid_calc;
                hi_next  = hi_calc;
                i_next   = lo_reg[CNT_W-1:0];
                j_next   = mid_calc;
                k_next   = lo_reg[CNT_W-1:0];
            end
            OP_STEP:
            begin
                i_next = i_reg + CNT_W'(take_left);
                j_next = j_reg + CNT_W'(!take_left);
                k_next = k_inc;
                if (status.merge_last)
                begin
                    lo_next = lo_plus_2w;
                end
            end
            OP_DRAIN_START:
            begin
                k_next = '0;
            end
            OP_EMIT:
            begin
                k_next         = k_inc;
                out_valid_next = 1'b1;
                if (status.drain_last)
                begin
                    count_next = '0;
                    drop_next  = 1'b0;
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            width_reg     <= '0;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            width_reg     <= width_next;
            lo_reg        <= lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_emit)
        begin
            sorted_value_reg <= src_a;
            last_out_reg     <= status.drain_last;
            overflow_reg     <= drop_reg;
        end
    end

    assign sorted_value = $signed(sorted_value_reg);
    assign last_out     = last_out_reg;
    assign overflow     = overflow_reg;
    assign out_valid    = out_valid_reg;

    // buffer 0 takes the loaded set; each pass writes the buffer it does not read
    assign wr_en0   = (is_load && room) || (is_step && src_reg);
    assign wr_en1   = is_step && !src_reg;
    assign wr_addr0 = is_load ? count_reg[ADDR_W-1:0] : k_reg[ADDR_W-1:0];
    assign wr_data0 = is_load ? value : winner;

    // read addresses follow the next pointers so data lines up with the step
    assign rd_addr_a = cmd.drain_sel ? k_reg[ADDR_W-1:0] : i_next[ADDR_W-1:0];
    assign rd_addr_b = j_next[ADDR_W-1:0];

    msort_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_buf0 (
        .clk       (clk),
        .wr_en     (wr_en0),
        .wr_addr   (wr_addr0),
        .wr_data   (wr_data0),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd0_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd0_b)
    );

    msort_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_buf1 (
        .clk       (clk),
        .wr_en     (wr_en1),
        .wr_addr   (k_reg[ADDR_W-1:0]),
        .wr_data   (winner),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd1_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd1_b)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_step_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        is_step |-> (k_reg < hi_reg) && (i_lt_mid || j_lt_hi))
        else $error("merge step outside its run");

    a_step_balance: assert property (@(posedge clk) disable iff (!rst_n)
        is_step |-> (SUM_W'(i_reg) + SUM_W'(j_reg)) == (SUM_W'(k_reg) + SUM_W'(mid_reg)))
        else $error("merge pointers out of step");

    a_set_end: assert property (@(posedge clk) disable iff (!rst_n)
        (is_emit && status.drain_last) |=>
            (count_reg == '0) && !drop_reg && out_valid_reg && last_out_reg)
        else $error("set not closed after final beat");

endmodule

// ===== rtl/core/merge_sorter.sv =====
// Merge sorter. Loads signed 32-bit values one beat per cycle until a beat with
// last_in set, then sorts them ascending (stable, earlier value first on ties) by
// bottom-up merge passes between two 64-entry buffers and sends them out, the
// final beat with last_out set and every beat carrying the overflow flag of the
// set. Beyond 64 values further beats are dropped and overflow is reported. For
// n stored values a set is loaded, a start step follows, then ceil(log2 n)
// merge passes, each opened and closed by its own step, with one setup step per
// run pair and one merged element per step; then the drain is started and each
// beat is read from the registered ram and then emitted when the output is free.
// Input is held off from the last beat until the final result is in the output
// register. No clearing pass after reset. Depends on msort_pkg, msort_ctrl,
// msort_dp and msort_ram.

module merge_sorter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [msort_pkg::DATA_W-1:0] value,
    input  logic                                last_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [msort_pkg::DATA_W-1:0] sorted_value,
    output logic                                last_out,
    output logic                                overflow
);

    import msort_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    msort_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last_in  (last_in),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    msort_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (value),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule

// ===== dv/tb.sv =====
// self-checking testbench of merge_sorter: directed table, then random sets
// with random idling on both channels, checked against a sorting predictor
// depends on msort_pkg and the merge_sorter rtl

module tb;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int NUM_ITEMS      = 420;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_TAIL     = 200;
    localparam int CAPACITY       = msort_pkg::MAX_ELEMENTS;

    typedef logic signed [msort_pkg::DATA_W-1:0] elem_t;

    typedef struct {
        elem_t value;
        logic  last;
        logic  ovf;
    } sorted_beat_t;

    // reps > 1 sends value, value-1, ... with last only on the final beat
    typedef struct {
        elem_t value;
        logic  last;
        int    reps;
        bit    typed;
        elem_t exp_value;
        logic  exp_ovf;
    } dir_row_t;

    typedef enum {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SINK_STALL,
        PH_BOTH_IDLE
    } idle_phase_t;

    localparam elem_t VAL_MAX = 32'sh7fffffff;
    localparam elem_t VAL_MIN = 32'sh80000000;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    elem_t value     = '0;
    logic  last_in   = 1'b0;
    logic  out_stall = 1'b0;
    logic  in_stall;
    logic  out_valid;
    elem_t sorted_value;
    logic  last_out;
    logic  overflow;

    idle_phase_t  phase = PH_STEADY;
    elem_t        pending_elems[$];
    logic         pending_dropped = 1'b0;
    sorted_beat_t sorted_expect_q[$];
    sorted_beat_t want;
    dir_row_t     dir_rows[$];

    int error_cnt       = 0;
    int beats_sent      = 0;
    int sets_sent       = 0;
    int overflow_sets   = 0;
    int results_checked = 0;
    int idle_cycles     = 0;

    merge_sorter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .last_in      (last_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // stores one beat; on the last beat of a set queues the stable ascending order
    function automatic void load_and_sort(elem_t v, logic l);
        elem_t        arr[CAPACITY];
        elem_t        key;
        int           n;
        int           j;
        sorted_beat_t b;
        if (pending_elems.size() < CAPACITY)
            pending_elems.push_back(v);
        else
            pending_dropped = 1'b1;
        if (!l)
            return;
        n = pending_elems.size();
        for (int i = 0; i < n; i++)
            arr[i] = pending_elems[i];
        // insertion sort with a strict compare keeps equal values in arrival order
        for (int i = 1; i < n; i++)
        begin
            key = arr[i];
            j = i - 1;
            while (j >= 0 && arr[j] > key)
            begin
                arr[j + 1] = arr[j];
                j--;
            end
            arr[j + 1] = key;
        end
        for (int i = 0; i < n; i++)
        begin
            b.value = arr[i];
            b.last  = (i == n - 1);
            b.ovf   = pending_dropped;
            sorted_expect_q.push_back(b);
        end
        sets_sent++;
        if (pending_dropped)
            overflow_sets++;
        pending_elems.delete();
        pending_dropped = 1'b0;
    endfunction

    function automatic void add_row(elem_t v, logic l, int reps, bit typed,
                                    elem_t exp_value, logic exp_ovf);
        dir_row_t r;
        r.value     = v;
        r.last      = l;
        r.reps      = reps;
        r.typed     = typed;
        r.exp_value = exp_value;
        r.exp_ovf   = exp_ovf;
        dir_rows.push_back(r);
    endfunction

    function automatic elem_t pick_value(int style);
        case (style)
            0: return elem_t'($urandom);
            1: return elem_t'($urandom_range(0, 6)) - 3;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return pick_value($urandom_range(0, 2));
        endcase
    endfunction

    function automatic int src_idle_pct();
        case (phase)
            PH_SRC_IDLE:  return 79;
            PH_BOTH_IDLE: return 6;
            default:      return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct();
        case (phase)
            PH_SINK_STALL: return 79;
            PH_BOTH_IDLE:  return 6;
            default:       return 0;
        endcase
    endfunction

    // presents one beat, holds it until accepted, then feeds the predictor
    task automatic send_beat(elem_t v, logic l);
        while (roll(src_idle_pct()))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last_in  <= l;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        load_and_sort(v, l);
    endtask

    always @(posedge clk)
    begin
        out_stall <= roll(sink_stall_pct());
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (sorted_expect_q.size() == 0)
            begin
                error_cnt++;
                $display("%0t: unexpected sorted beat: expected none,", $time,
                         " got value %0d last %0b overflow %0b",
                         sorted_value, last_out, overflow);
            end
            else
            begin
                want = sorted_expect_q.pop_front();
                if (sorted_value !== want.value || last_out !== want.last
                    || overflow !== want.ovf)
                begin
                    error_cnt++;
                    $display("%0t: sorted beat mismatch:", $time,
                             " expected value %0d last %0b overflow %0b,",
                             want.value, want.last, want.ovf,
                             " got value %0d last %0b overflow %0b",
                             sorted_value, last_out, overflow);
                end
            end
        end
    end

    // any cycle with a beat on either channel restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, no beat for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, sorted_expect_q.size());
                $display("merge_sorter regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int set_idx;
        int set_size;
        int style;
        int sel;
        dir_row_t row;
        sorted_beat_t typed_beat;

        // single-value sets read off directly, then ties, ordering and buffer limits
        add_row(VAL_MAX, 1'b1, 1, 1'b1, VAL_MAX, 1'b0);
        add_row(VAL_MIN, 1'b1, 1, 1'b1, VAL_MIN, 1'b0);
        add_row('0,      1'b1, 1, 1'b1, '0,      1'b0);
        add_row(-1,      1'b1, 1, 1'b1, -1,      1'b0);
        add_row(3,       1'b0, 1, 1'b0, '0, 1'b0);
        add_row(-2,      1'b0, 1, 1'b0, '0, 1'b0);
        add_row(VAL_MAX, 1'b0, 1, 1'b0, '0, 1'b0);
        add_row(VAL_MIN, 1'b0, 1, 1'b0, '0, 1'b0);
        add_row(-2,      1'b0, 1, 1'b0, '0, 1'b0);
        add_row(3,       1'b1, 1, 1'b0, '0, 1'b0);
        add_row(5,       1'b1, 5, 1'b0, '0, 1'b0);
        add_row(9,       1'b0, 1, 1'b0, '0, 1'b0);
        add_row(9,       1'b1, 1, 1'b0, '0, 1'b0);
        add_row(VAL_MIN + 1, 1'b0, 1, 1'b0, '0, 1'b0);
        add_row(VAL_MAX, 1'b1, 2, 1'b0, '0, 1'b0);
        // full buffer exactly, last beat dropped, several beats dropped
        add_row(100,     1'b1, CAPACITY,     1'b0, '0, 1'b0);
        add_row('0,      1'b1, CAPACITY + 1, 1'b0, '0, 1'b0);
        add_row(-5,      1'b1, CAPACITY + 6, 1'b0, '0, 1'b0);
        // overflow must not leak into the next set
        add_row(42,      1'b1, 1, 1'b1, 42, 1'b0);

        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        phase = PH_STEADY;
        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            for (int i = 0; i < row.reps; i++)
                send_beat(row.value - elem_t'(i), row.last && (i == row.reps - 1));
            if (row.typed)
            begin
                typed_beat.value = row.exp_value;
                typed_beat.last  = 1'b1;
                typed_beat.ovf   = row.exp_ovf;
                sorted_expect_q[sorted_expect_q.size() - 1] = typed_beat;
            end
        end

        set_idx = 0;
        while (beats_sent < NUM_ITEMS)
        begin
            phase = idle_phase_t'(set_idx % 4);
            if (set_idx == 3)
            begin
                in_valid <= 1'b0;
                while (sorted_expect_q.size() != 0)
                    @(posedge clk);
            end
            // mostly small sets, some medium and large ones up to capacity and a few past it
            sel = $urandom_range(0, 99);
            if (sel < 60)
                set_size = $urandom_range(1, 8);
            else if (sel < 80)
                set_size = $urandom_range(9, 32);
            else if (sel < 92)
                set_size = $urandom_range(33, CAPACITY);
            else
                set_size = $urandom_range(CAPACITY + 1, CAPACITY + 8);
            style = $urandom_range(0, 3);
            for (int i = 0; i < set_size; i++)
                send_beat(pick_value(style), i == set_size - 1);
            set_idx++;
        end
        in_valid <= 1'b0;

        while (sorted_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("covered %0d input beats in %0d sets (%0d past capacity)",
                 beats_sent, sets_sent, overflow_sets);
        $display("compared %0d sorted beats over four idling patterns, %0d errors",
                 results_checked, error_cnt);
        if (error_cnt == 0)
            $display("merge_sorter regression: pass");
        else
            $display("merge_sorter regression: fail");
        $finish;
    end

endmodule
